// ===== design/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants of the triangle face normal unit
// Default widths, the fixed output width, the normalization target and the
// per-stage tag that travels down the pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int TFN_COORD_WIDTH    = 16;
  localparam int TFN_NORM_FRAC_BITS = 14;

  // width of each normal component on the output port
  localparam int TFN_OUT_W = 16;

  // leading one of the largest cross magnitude lands on this bit
  localparam int TFN_NORM_TGT = 30;

  typedef struct packed {
    logic       vld;
    logic       degen;
    logic [2:0] neg;
  } tfn_tag_t;

endpackage

// ===== design/triangle_face_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of one triangle
// The 32-step square root and the NORM_FRAC_BITS + 1 step dividers make up
// most of the pipeline depth.
// Throughput: one triangle word per cycle; the whole pipe holds while a
// finished result is stalled at the output register.
// Reset (rst, synchronous): clears every stage valid bit; no words are held.
// ----------------------------------------------------------------------------
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH    = TFN_COORD_WIDTH,
  parameter int NORM_FRAC_BITS = TFN_NORM_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [TFN_OUT_W-1:0]   nx,
  output logic signed [TFN_OUT_W-1:0]   ny,
  output logic signed [TFN_OUT_W-1:0]   nz,
  output logic                          degenerate
);

  // Edge pre-shift for very wide coordinates keeps edges at 31 bits.
  localparam int ESH  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int EW   = COORD_WIDTH - ESH + 1;      // edge width
  localparam int MW   = 2 * EW;                     // cross magnitude width
  localparam int PW   = $clog2(MW);                 // leading-one position
  localparam int SW   = TFN_NORM_TGT + 1;           // normalized magnitude
  localparam int SQW  = 2 * SW;                     // one square
  localparam int SUMW = SQW + 2;                    // sum of three squares
  localparam int RW   = SUMW / 2;                   // square root width
  localparam int FB   = NORM_FRAC_BITS;
  localparam int QW   = FB + 1;                     // quotient width
  localparam int NW   = RW + FB + 1;                // dividend width

  // Whole pipe moves together; it holds only while a result waits.
  logic adv;

  tfn_tag_t out_tag;
  assign out_valid = out_tag.vld;
  assign adv       = !out_tag.vld || !out_stall;
  assign in_stall  = !adv;

  // ---------------------------------------------------------------- stage 0
  // Edges u = a - b and v = c - b.
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic signed [COORD_WIDTH:0]   du [3];
  logic signed [COORD_WIDTH:0]   dv [3];

  assign pa[0] = ax;
  assign pa[1] = ay;
  assign pa[2] = az;
  assign pb[0] = bx;
  assign pb[1] = by;
  assign pb[2] = bz;
  assign pc[0] = cx;
  assign pc[1] = cy;
  assign pc[2] = cz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du[i] = $signed({pa[i][COORD_WIDTH-1], pa[i]}) - $signed({pb[i][COORD_WIDTH-1], pb[i]});
      dv[i] = $signed({pc[i][COORD_WIDTH-1], pc[i]}) - $signed({pb[i][COORD_WIDTH-1], pb[i]});
    end
  end

  logic signed [EW-1:0] s0_u [3];
  logic signed [EW-1:0] s0_v [3];
  tfn_tag_t             s0_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= '0;
    end else if (adv) begin
      s0_tag <= '{vld: in_valid, degen: 1'b0, neg: 3'b000};
      for (int i = 0; i < 3; i++) begin
        s0_u[i] <= EW'(du[i] >>> ESH);
        s0_v[i] <= EW'(dv[i] >>> ESH);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Six partial products of the cross product.
  logic signed [MW-1:0] s1_p [6];
  tfn_tag_t             s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
    end else if (adv) begin
      s1_tag  <= s0_tag;
      s1_p[0] <= s0_u[1] * s0_v[2];
      s1_p[1] <= s0_u[2] * s0_v[1];
      s1_p[2] <= s0_u[2] * s0_v[0];
      s1_p[3] <= s0_u[0] * s0_v[2];
      s1_p[4] <= s0_u[0] * s0_v[1];
      s1_p[5] <= s0_u[1] * s0_v[0];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Cross components, split into magnitude and sign.
  logic signed [MW:0] cr [3];
  logic [MW-1:0]      s2_mag [3];
  tfn_tag_t           s2_tag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = $signed({s1_p[2*i][MW-1], s1_p[2*i]})
            - $signed({s1_p[2*i+1][MW-1], s1_p[2*i+1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
    end else if (adv) begin
      s2_tag <= '{vld: s1_tag.vld, degen: s1_tag.degen,
                  neg: {cr[2][MW], cr[1][MW], cr[0][MW]}};
      for (int i = 0; i < 3; i++) begin
        s2_mag[i] <= cr[i][MW] ? MW'(-cr[i]) : MW'(cr[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Leading one of the largest magnitude equals that of the OR of all three.
  function automatic logic [PW-1:0] lead_one(input logic [MW-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int b = 0; b < MW; b++) begin
      if (v[b]) p = PW'(b);
    end
    return p;
  endfunction

  logic [MW-1:0] mag_or;
  logic [MW-1:0] s3_mag [3];
  logic [PW-1:0] s3_pos;
  tfn_tag_t      s3_tag;

  assign mag_or = s2_mag[0] | s2_mag[1] | s2_mag[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (adv) begin
      s3_tag <= '{vld: s2_tag.vld, degen: (mag_or == '0), neg: s2_tag.neg};
      s3_pos <= lead_one(mag_or);
      s3_mag <= s2_mag;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Place the leading one on the target bit: pre-shift left, then right by
  // its position, dropping the bits that fall off (truncating magnitude).
  logic [MW+TFN_NORM_TGT-1:0] wide [3];
  logic [SW-1:0]              s4_mag [3];
  tfn_tag_t                   s4_tag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {s3_mag[i], {TFN_NORM_TGT{1'b0}}} >> s3_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag <= '0;
    end else if (adv) begin
      s4_tag <= s3_tag;
      for (int i = 0; i < 3; i++) begin
        s4_mag[i] <= wide[i][SW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [SQW-1:0] s5_sq [3];
  logic [SW-1:0]  s5_mag [3];
  tfn_tag_t       s5_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_tag <= '0;
    end else if (adv) begin
      s5_tag <= s4_tag;
      s5_mag <= s4_mag;
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= s4_mag[i] * s4_mag[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic [SUMW-1:0] s6_sum;
  logic [SW-1:0]   s6_mag [3];
  tfn_tag_t        s6_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_tag <= '0;
    end else if (adv) begin
      s6_tag <= s5_tag;
      s6_mag <= s5_mag;
      s6_sum <= SUMW'(s5_sq[0]) + SUMW'(s5_sq[1]) + SUMW'(s5_sq[2]);
    end
  end

  // ------------------------------------------------------------ square root
  // One result bit per stage, most significant first, remainder form.
  logic [SUMW-1:0] sq_rem  [RW];
  logic [RW-1:0]   sq_root [RW];
  logic [SW-1:0]   sq_mag  [RW][3];
  tfn_tag_t        sq_tag  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int BIT = RW - 1 - j;
    logic [SUMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   mag_in [3];
    tfn_tag_t        tag_in;
    logic [SUMW:0]   trial;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in  = s6_sum;
      assign root_in = '0;
      assign mag_in  = s6_mag;
      assign tag_in  = s6_tag;
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign mag_in  = sq_mag[j-1];
      assign tag_in  = sq_tag[j-1];
    end

    assign trial = ((SUMW+1)'(root_in) << (BIT + 1)) | ((SUMW+1)'(1) << (2 * BIT));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_tag[j] <= '0;
      end else if (adv) begin
        sq_tag[j]  <= tag_in;
        sq_mag[j]  <= mag_in;
        sq_rem[j]  <= take ? rem_in - trial[SUMW-1:0] : rem_in;
        sq_root[j] <= take ? (root_in | (RW'(1) << BIT)) : root_in;
      end
    end
  end

  // -------------------------------------------------------------- dividend
  // mag * 2^FB + floor(L / 2), so the quotient rounds half up.
  logic [RW-1:0] len;
  logic [NW-1:0] nm_num [3];
  logic [RW-1:0] nm_len;
  tfn_tag_t      nm_tag;

  assign len = sq_root[RW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_tag <= '0;
    end else if (adv) begin
      nm_tag <= sq_tag[RW-1];
      nm_len <= len;
      for (int i = 0; i < 3; i++) begin
        nm_num[i] <= (NW'(sq_mag[RW-1][i]) << FB) + NW'(len >> 1);
      end
    end
  end

  // -------------------------------------------------------------- dividers
  // Restoring division, one quotient bit per stage for all three lanes.
  logic [NW-1:0] dq_rem [QW][3];
  logic [QW-1:0] dq_q   [QW][3];
  logic [RW-1:0] dq_len [QW];
  tfn_tag_t      dq_tag [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int BIT = QW - 1 - j;
    logic [NW-1:0] rem_in [3];
    logic [QW-1:0] q_in   [3];
    logic [RW-1:0] len_in;
    tfn_tag_t      tag_in;
    logic [NW-1:0] dsr;

    if (j == 0) begin : g_first
      assign rem_in = nm_num;
      assign q_in   = '{default: '0};
      assign len_in = nm_len;
      assign tag_in = nm_tag;
    end else begin : g_next
      assign rem_in = dq_rem[j-1];
      assign q_in   = dq_q[j-1];
      assign len_in = dq_len[j-1];
      assign tag_in = dq_tag[j-1];
    end

    assign dsr = NW'(len_in) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        dq_tag[j] <= '0;
      end else if (adv) begin
        dq_tag[j] <= tag_in;
        dq_len[j] <= len_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dsr) begin
            dq_rem[j][i] <= rem_in[i] - dsr;
            dq_q[j][i]   <= q_in[i] | (QW'(1) << BIT);
          end else begin
            dq_rem[j][i] <= rem_in[i];
            dq_q[j][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------- output stage
  // Apply the sign after rounding; force zeros on a degenerate triangle.
  logic [TFN_OUT_W-1:0] qo  [3];
  logic [TFN_OUT_W-1:0] res [3];
  tfn_tag_t             fin;

  assign fin = dq_tag[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qo[i]  = TFN_OUT_W'(dq_q[QW-1][i]);
      res[i] = fin.degen ? '0 : (fin.neg[i] ? -qo[i] : qo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag    <= fin;
      nx         <= res[0];
      ny         <= res[1];
      nz         <= res[2];
      degenerate <= fin.degen;
    end
  end

  // ------------------------------------------------------------ assertions
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> nx == '0 && ny == '0 && nz == '0)
    else $error("degenerate result with nonzero normal");

  a_norm_lead: assert property (@(posedge clk) disable iff (rst)
    s4_tag.vld && !s4_tag.degen |->
      ((s4_mag[0] | s4_mag[1] | s4_mag[2]) >> TFN_NORM_TGT) == SW'(1))
    else $error("normalized magnitude off target bit");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_tag[RW-1].vld && !sq_tag[RW-1].degen |->
      len >= RW'(sq_mag[RW-1][0]) && len >= RW'(sq_mag[RW-1][1])
      && len >= RW'(sq_mag[RW-1][2]))
    else $error("root below a component magnitude");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    fin.vld && !fin.degen |->
      dq_q[QW-1][0] <= (QW'(1) << FB) && dq_q[QW-1][1] <= (QW'(1) << FB)
      && dq_q[QW-1][2] <= (QW'(1) << FB))
    else $error("normal component above unit length");

endmodule

// ===== dv/triangle_face_normal_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_tb: self-checking bench for the face normal unit
// Streams triangles through the block with random gaps and output stalls,
// predicts each unit normal in integer arithmetic and checks every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_face_normal_tb;
  import tfn_pkg::*;

  localparam int CW        = TFN_COORD_WIDTH;
  localparam int FB        = TFN_NORM_FRAC_BITS;
  localparam int LATENCY   = 42 + FB;
  localparam int MAX_CYCLES = 400000;
  localparam int N_RANDOM  = 830;

  typedef logic signed [CW-1:0] coord_t;

  // one triangle: vertex a, pivot b, vertex c
  typedef struct {
    coord_t a[3];
    coord_t b[3];
    coord_t c[3];
  } tri_t;

  typedef struct {
    logic signed [TFN_OUT_W-1:0] n[3];
    logic                        degen;
  } normal_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  logic out_valid;
  logic out_stall;
  logic signed [TFN_OUT_W-1:0] nx, ny, nz;
  logic degenerate;

  tri_t    tri_pending[$];
  normal_t normal_expected[$];
  int      n_errors;
  int      cycle_count;
  bit      stim_done;
  bit      noidle;      // long stretch without any idling
  int      hold_left;   // receiver hold-off counter

  triangle_face_normal u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit.
  function automatic longint unsigned isqrt(longint unsigned val);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val = val - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Cross product of the edges u = a - b and v = c - b, scaled to unit length in fixed point.
  function automatic normal_t face_normal(tri_t t);
    normal_t         r;
    longint          u[3], v[3], cr[3];
    longint unsigned mag[3], m, s, len, q;
    bit              neg[3];
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(t.a[i]) - longint'(t.b[i]);
      v[i] = longint'(t.c[i]) - longint'(t.b[i]);
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? longint'(-cr[i]) : cr[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      foreach (r.n[i]) r.n[i] = '0;
      r.degen = 1'b1;
      return r;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (len >> 1)) / len;
      if (neg[i]) q = 64'd0 - q;
      r.n[i] = q[TFN_OUT_W-1:0];
    end
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'(-(1 << (CW - 1)));
      1: return coord_t'((1 << (CW - 1)) - 1);
      2: return coord_t'($urandom_range(0, 15)) - 8;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic push_tri(coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.a = '{a0, a1, a2};
    t.b = '{b0, b1, b2};
    t.c = '{c0, c1, c2};
    tri_pending.push_back(t);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
             want);
    n_errors++;
  endtask

  // Fill the pending queue: directed corners first, then random triangles.
  initial begin
    coord_t mn, mx;
    tri_t   t;
    int     kind;
    mn = coord_t'(-(1 << (CW - 1)));
    mx = coord_t'((1 << (CW - 1)) - 1);
    // degenerate: all vertices coincide, collinear, all at the extremes
    push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
    push_tri(mx, mx, mx, mx, mx, mx, mn, mn, mn);
    // axis-aligned unit triangles, each sign of each axis
    push_tri(1, 0, 0, 0, 0, 0, 0, 1, 0);
    push_tri(0, 1, 0, 0, 0, 0, 1, 0, 0);
    push_tri(0, 1, 0, 0, 0, 0, 0, 0, 1);
    push_tri(0, 0, 1, 0, 0, 0, 0, 1, 0);
    push_tri(0, 0, 1, 0, 0, 0, 1, 0, 0);
    push_tri(1, 0, 0, 0, 0, 0, 0, 0, 1);
    // largest edges, both signs, so the cross product needs a right shift
    push_tri(mx, mn, 0, mn, mx, 0, mx, mx, mn);
    push_tri(mn, mx, mx, mx, mn, mn, mn, mn, mx);
    push_tri(mx, 0, 0, mn, 0, 0, mn, mx, 0);
    push_tri(mn, mn, mn, mx, 0, mx, 0, mx, mn);
    // tiny cross product, large left shift; diagonal normals
    push_tri(1, 0, 0, 0, 0, 0, 0, 0, -1);
    push_tri(1, 0, 0, 0, 0, 0, 1, 1, 1);
    push_tri(-1, -1, 0, 0, 0, 0, 0, -1, -1);
    push_tri(mx, mx, mx, 0, 0, 0, mn, mx, 0);
    push_tri(-1, 0, 0, 0, 0, 0, 0, mx, mn);
    push_tri(3, -7, 5, -2, 9, -4, 6, 1, -8);
    push_tri(mn, 0, mx, -1, -1, -1, mx, mn, 0);
    for (int k = 0; k < N_RANDOM; k++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
        t.a[i] = rand_coord();
        t.b[i] = rand_coord();
        t.c[i] = rand_coord();
      end
      if (kind == 0) begin
        // collinear: c = b + 2(a - b), kept small to stay in range
        for (int i = 0; i < 3; i++) begin
          t.b[i] = coord_t'($urandom_range(0, 2000)) - 1000;
          t.a[i] = t.b[i] + coord_t'($urandom_range(0, 200)) - 100;
          t.c[i] = t.b[i] + 2 * (t.a[i] - t.b[i]);
        end
      end else if (kind == 1) begin
        // small local triangle
        for (int i = 0; i < 3; i++) begin
          t.a[i] = t.b[i] + coord_t'($urandom_range(0, 6)) - 3;
          t.c[i] = t.b[i] + coord_t'($urandom_range(0, 6)) - 3;
        end
      end
      tri_pending.push_back(t);
    end
  end

  // Reset, then watch for the end of the run.
  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && normal_expected.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (n_errors == 0) begin
      $display("triangle_face_normal_tb: PASS");
    end else begin
      $display("triangle_face_normal_tb: FAIL");
    end
    $finish;
  end

  // Cycle count; give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("triangle_face_normal_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    n_errors = 0;
    stim_done = 1'b0;
    noidle = 1'b0;
    hold_left = 0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
  end

  // Turn idling off for a stretch in the middle of the run.
  always @(posedge clk) begin
    if (cycle_count == 1000) noidle <= 1'b1;
    if (cycle_count == 1300) noidle <= 1'b0;
  end

  // Driver: advance to the next word only after a handshake; hold a stalled
  // word unchanged. Predict at acceptance.
  always @(posedge clk) begin
    tri_t t;
    bit   fire;
    if (!rst) begin
      fire = in_valid && !in_stall;
      if (fire) normal_expected.push_back(face_normal(tri_pending.pop_front()));
      if (!in_valid || fire) begin
        if (tri_pending.size() > 0 && (noidle || $urandom_range(0, 99) >= 28)) begin
          t = tri_pending[0];
          in_valid <= 1'b1;
          ax <= t.a[0]; ay <= t.a[1]; az <= t.a[2];
          bx <= t.b[0]; by <= t.b[1]; bz <= t.b[2];
          cx <= t.c[0]; cy <= t.c[1]; cz <= t.c[2];
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (tri_pending.size() == 0 && (fire || !in_valid)) stim_done <= 1'b1;
    end
  end

  // Receiver stall: one long hold-off so the pipe fills and backs up,
  // otherwise random stalls outside the no-idle stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (cycle_count == 600) begin
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= !noidle && ($urandom_range(0, 99) < 28);
    end
  end

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    normal_t want;
    if (!rst && out_valid && !out_stall) begin
      if (normal_expected.size() == 0) begin
        report_mismatch("unexpected word, degenerate", degenerate, -1);
      end else begin
        want = normal_expected.pop_front();
        if (nx !== want.n[0]) report_mismatch("nx", nx, want.n[0]);
        if (ny !== want.n[1]) report_mismatch("ny", ny, want.n[1]);
        if (nz !== want.n[2]) report_mismatch("nz", nz, want.n[2]);
        if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
      end
    end
  end

endmodule
